// ===== rtl/core/date_difference_days_unit_macros.svh =====
// Assertion macros shared by the date difference RTL
`ifndef DATE_DIFFERENCE_DAYS_UNIT_MACROS_SVH
`define DATE_DIFFERENCE_DAYS_UNIT_MACROS_SVH

// same-cycle implication
`define DDD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ddd_pkg.sv =====
// Shared types and constants of the date difference unit
package ddd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int NUM_W   = 23;
	localparam int DIFF_W  = 23;

	localparam logic [DIFF_W-1:0] DIFF_MAX = 23'h3FFFFF;
	localparam logic [DIFF_W-1:0] DIFF_MIN = 23'h400000;

	localparam int DAYS_PER_YEAR = 365;
	localparam int CENTURY       = 100;
	localparam int RECIP_100     = 5243;
	localparam int RECIP_SHIFT   = 19;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [NUM_W-1:0] num_a;
		logic [NUM_W-1:0] num_b;
	} ddd_pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ddd_qstat_t;

endpackage

// ===== rtl/core/date_difference_days_unit.sv =====
// Top level of the date difference unit
// Takes two proleptic Gregorian dates and returns the signed day count from the
// first to the second, saturated to 23 bits. One date pair is accepted every
// cycle while full is low. Two front stages turn each date into a day number,
// a four-entry queue decouples them from the subtracting back end, and one
// output register holds the result item until popped. Day values past the
// month length simply add on; month zero counts as January.
`include "date_difference_days_unit_macros.svh"

module date_difference_days_unit import ddd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [YEAR_W-1:0]        year_a,
	input  logic [MONTH_W-1:0]       month_a,
	input  logic [DAY_W-1:0]         day_a,
	input  logic [YEAR_W-1:0]        year_b,
	input  logic [MONTH_W-1:0]       month_b,
	input  logic [DAY_W-1:0]         day_b,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DIFF_W-1:0] diff_days
);

	ddd_qstat_t qstat;
	logic       q_push;
	logic       q_pop;
	ddd_pair_t  q_wr;
	ddd_pair_t  q_rd;

	ddd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.year_a  (year_a),
		.month_a (month_a),
		.day_a   (day_a),
		.year_b  (year_b),
		.month_b (month_b),
		.day_b   (day_b),
		.qstat   (qstat),
		.q_push  (q_push),
		.q_data  (q_wr)
	);

	ddd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.qstat   (qstat)
	);

	ddd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.rd_data   (q_rd),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.diff_days (diff_days)
	);

	`DDD_ASSERT_IMP(ast_queue_feeds_out, clk, arst_n, empty && !qstat.empty, q_pop,
		"waiting item not moved to empty output")
	`DDD_ASSERT_NXT(ast_pop_fills_out, clk, arst_n, q_pop, !empty,
		"item taken from queue but output empty")

endmodule

// ===== rtl/core/ddd_front.sv =====
// Front end: accept date pairs and reduce each date to a running day number
`include "date_difference_days_unit_macros.svh"

module ddd_front import ddd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [YEAR_W-1:0]  year_a,
	input  logic [MONTH_W-1:0] month_a,
	input  logic [DAY_W-1:0]   day_a,
	input  logic [YEAR_W-1:0]  year_b,
	input  logic [MONTH_W-1:0] month_b,
	input  logic [DAY_W-1:0]   day_b,
	input  ddd_qstat_t         qstat,
	output logic               q_push,
	output ddd_pair_t          q_data
);

	typedef struct packed {
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
	} date_t;

	typedef struct packed {
		date_t      dt;
		logic [7:0] yq;
		logic [5:0] q400;
	} date_cls_t;

	function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			4'd13:   r = 9'd365;
			4'd14:   r = 9'd396;
			4'd15:   r = 9'd427;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic date_cls_t classify(input date_t dt);
		date_cls_t   c;
		logic [27:0] p_yq;
		logic [14:0] t400;
		logic [27:0] p_400;
		p_yq   = 28'(dt.y) * 28'(RECIP_100);
		t400   = 15'(dt.y) + 15'd399;
		p_400  = 28'(t400[14:2]) * 28'(RECIP_100);
		c.dt   = dt;
		c.yq   = 8'(p_yq >> RECIP_SHIFT);
		c.q400 = 6'(p_400 >> RECIP_SHIFT);
		return c;
	endfunction

	function automatic logic [NUM_W-1:0] day_number(input date_cls_t c);
		logic        rem_zero;
		logic        leap;
		logic [8:0]  q100;
		logic [14:0] q4;
		logic [23:0] n;
		rem_zero = (15'(c.dt.y) == 15'(c.yq) * 15'(CENTURY));
		q100     = 9'(c.yq) + 9'(!rem_zero);
		leap     = (c.dt.y[1:0] == 2'd0) && (!rem_zero || c.dt.y[3:0] == 4'd0);
		q4       = (15'(c.dt.y) + 15'd3) >> 2;
		n = 24'(c.dt.y) * 24'(DAYS_PER_YEAR) + 24'(q4) - 24'(q100) + 24'(c.q400)
			+ 24'(month_start(c.dt.m)) + 24'(leap && (c.dt.m >= 4'd3)) + 24'(c.dt.d);
		return n[NUM_W-1:0];
	endfunction

	logic      v_s1;
	date_t     a_s1;
	date_t     b_s1;
	logic      v_s2;
	date_cls_t a_s2;
	date_cls_t b_s2;
	logic      s1_ready;
	logic      s2_ready;

	assign s2_ready = !v_s2 || !qstat.full;
	assign s1_ready = !v_s1 || s2_ready;
	assign full     = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= push;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && s1_ready) begin
			a_s1 <= '{y: year_a, m: month_a, d: day_a};
			b_s1 <= '{y: year_b, m: month_b, d: day_b};
		end
		if (v_s1 && s2_ready) begin
			a_s2 <= classify(a_s1);
			b_s2 <= classify(b_s1);
		end
	end

	assign q_push       = v_s2 && !qstat.full;
	assign q_data.num_a = day_number(a_s2);
	assign q_data.num_b = day_number(b_s2);

	`DDD_ASSERT_NXT(ast_s1_hold, clk, arst_n, v_s1 && !s2_ready,
		v_s1 && $stable(a_s1) && $stable(b_s1), "stage 1 item lost while stalled")
	`DDD_ASSERT_NXT(ast_s2_hold, clk, arst_n, v_s2 && qstat.full,
		v_s2 && $stable(a_s2) && $stable(b_s2), "stage 2 item lost while stalled")

endmodule

// ===== rtl/core/ddd_fifo.sv =====
// Short queue between front and back
`include "date_difference_days_unit_macros.svh"

module ddd_fifo import ddd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ddd_pair_t  wr_data,
	input  logic       pop,
	output ddd_pair_t  rd_data,
	output ddd_qstat_t qstat
);

	ddd_pair_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign qstat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_data     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	`DDD_ASSERT_IMP(ast_no_overflow, clk, arst_n, push, !qstat.full || pop,
		"item pushed into full queue")
	`DDD_ASSERT_IMP(ast_no_underflow, clk, arst_n, pop, !qstat.empty,
		"item popped from empty queue")

endmodule

// ===== rtl/core/ddd_back.sv =====
// Back end: subtract day numbers, saturate and hold the result item
module ddd_back import ddd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ddd_qstat_t               qstat,
	input  ddd_pair_t                rd_data,
	output logic                     q_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DIFF_W-1:0] diff_days
);

	logic              v_q;
	logic [DIFF_W-1:0] diff_q;
	logic [NUM_W:0]    raw;
	logic [DIFF_W-1:0] sat;

	assign q_pop = !qstat.empty && (!v_q || pop);
	assign raw   = {1'b0, rd_data.num_b} - {1'b0, rd_data.num_a};

	always_comb begin
		case (raw[NUM_W:NUM_W-1])
			2'b01:   sat = DIFF_MAX;
			2'b10:   sat = DIFF_MIN;
			default: sat = raw[DIFF_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (q_pop) begin
			v_q <= 1'b1;
		end else if (pop) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			diff_q <= sat;
		end
	end

	assign empty     = !v_q;
	assign diff_days = $signed(diff_q);

endmodule
